[design/bpe_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, codes and constants for the Bezier patch evaluator.
package bpe_pkg;

  localparam int MAX_ORDER   = 4;
  localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  localparam int COORD_W = 32;
  localparam int PARAM_W = 18;
  localparam int ORDER_W = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ORDER_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_U = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_V = 1'd1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_MIN   = 3'd2;
  localparam logic [ORDER_W-1:0] ORDER_QUAD  = 3'd3;
  localparam logic [ORDER_W-1:0] ORDER_CUBIC = 3'd4;
  localparam logic [ORDER_W-1:0] ORDER_RST   = 3'd4;

endpackage

[design/bpe_in_if.sv]
`timescale 1ns / 1ps
// Input channel: control point loads and surface evaluation requests.
interface bpe_in_if;
  import bpe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [IDX_W-1:0]          point_index;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [PARAM_W-1:0] param_u;
  logic signed [PARAM_W-1:0] param_v;

  modport source (
    output valid, kind, point_index, point_x, point_y, param_u, param_v,
    input  ready
  );

  modport sink (
    input  valid, kind, point_index, point_x, point_y, param_u, param_v,
    output ready
  );

endinterface

[design/bpe_out_if.sv]
`timescale 1ns / 1ps
// Output channel: evaluated surface point and saturation flag.
interface bpe_out_if;
  import bpe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] surface_x;
  logic signed [COORD_W-1:0] surface_y;
  logic                      overflow;

  modport source (
    output valid, surface_x, surface_y, overflow,
    input  ready
  );

  modport sink (
    input  valid, surface_x, surface_y, overflow,
    output ready
  );

endinterface

[design/bezier_patch_evaluator.sv]
`timescale 1ns / 1ps
// Bezier patch evaluator: one shared 32x32 multiply-accumulate unit under a sequencer.
// Load transfer: stores the point, no result. Evaluate: per axis the sequencer forms the
// weights (cubic squares s and t first, each term in high and low parts), then per control
// point issues a weight, an idle slot, an x and a y product; ready again when the result
// enters the output register. At most one issue a cycle. Reset (async, active low) sets both
// orders to 4 and empties the output register; the control point store is not cleared.
module bezier_patch_evaluator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bpe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  bpe_in_if.sink                          in_ch,
  bpe_out_if.source                       out_ch
);
  import bpe_pkg::*;

  localparam int ACC_W  = 66;
  localparam int PROD_W = 64;
  localparam int SPLIT  = 19;

  localparam logic signed [ACC_W-1:0] RND_C8  = ACC_W'(1) <<< 7;
  localparam logic signed [ACC_W-1:0] RND_C24 = ACC_W'(1) <<< 23;
  localparam logic signed [ACC_W-1:0] RND_C32 = ACC_W'(1) <<< 31;
  localparam logic signed [ACC_W-1:0] RND_C16 = ACC_W'(1) <<< 15;
  localparam logic signed [31:0]      ONE_Q16 = 32'sd65536;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_TERM, ST_GAP, ST_POINT, ST_DRAIN, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_SS, DST_TT, DST_WU, DST_WV, DST_W, DST_X, DST_Y
  } dest_e;

  typedef enum logic [1:0] {RND_0, RND_8, RND_24, RND_32} rnd_e;

  typedef struct packed {
    dest_e      dest;
    logic       first;
    logic       hi;
    rnd_e       rnd;
    logic [1:0] idx;
  } mac_ctl_t;

  function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] r);
    logic [ORDER_W-1:0] o;
    if (r < ORDER_MIN) o = ORDER_MIN;
    else if (r > ORDER_W'(MAX_ORDER)) o = ORDER_W'(MAX_ORDER);
    else o = r;
    return o;
  endfunction

  // {flag, value}: round-shifted accumulator saturated to Q16.16
  function automatic logic [COORD_W:0] sat_out(input logic signed [ACC_W-1:0] a);
    logic all1;
    logic all0;
    logic [COORD_W:0] r;
    all1 = &a[ACC_W-1:47];
    all0 = ~|a[ACC_W-1:47];
    if (all1 || all0) r = {1'b0, a[47:16]};
    else if (a[ACC_W-1]) r = {1'b1, 32'h8000_0000};
    else r = {1'b1, 32'h7FFF_FFFF};
    return r;
  endfunction

  // configuration
  logic [ORDER_W-1:0] order_u_q, order_v_q;
  logic [ORDER_W-1:0] eff_u, eff_v, ord_c;

  // sequencer
  state_e     state_q, state_d;
  logic       axis_q, axis_d;
  logic       pre_q, pre_d;
  logic       part_q, part_d;
  logic [1:0] term_q, term_d;
  logic [1:0] row_q, row_d, col_q, col_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [1:0] pstep_q, pstep_d;
  mac_ctl_t   ctl_q, ctl_d;
  logic       out_valid_q, out_valid_d;

  // datapath
  logic signed [COORD_W-1:0] xs_q [STORE_DEPTH];
  logic signed [COORD_W-1:0] ys_q [STORE_DEPTH];
  logic signed [PARAM_W-1:0] t_q  [2];
  logic signed [18:0]        s_q  [2];
  logic signed [20:0]        s3_q [2];
  logic signed [19:0]        t3_q [2];
  logic signed [37:0]        ss_q, tt_q;
  logic signed [31:0]        wu_q [MAX_ORDER];
  logic signed [31:0]        wv_q [MAX_ORDER];
  logic signed [31:0]        w_q;
  logic signed [ACC_W-1:0]   acc_q, acc_x_q, acc_y_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic                      out_ovf_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] base, addend, sum;
  logic signed [31:0] w_ext;
  logic signed [18:0] s_new_u, s_new_v;
  logic signed [18:0] s_c;
  logic signed [PARAM_W-1:0] t_c;
  logic signed [18:0] ss_hi, tt_hi;
  logic signed [19:0] ss_lo, tt_lo;
  logic accept, eval_start, out_load;
  logic [COORD_W:0] sat_x, sat_y;

  assign eff_u = eff_order(order_u_q);
  assign eff_v = eff_order(order_v_q);
  assign ord_c = axis_q ? eff_v : eff_u;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign eval_start  = accept && (in_ch.kind == KIND_EVAL);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

  assign out_ch.valid     = out_valid_q;
  assign out_ch.surface_x = out_x_q;
  assign out_ch.surface_y = out_y_q;
  assign out_ch.overflow  = out_ovf_q;

  assign s_new_u = 19'sd65536 - 19'(in_ch.param_u);
  assign s_new_v = 19'sd65536 - 19'(in_ch.param_v);

  assign s_c   = s_q[axis_q];
  assign t_c   = t_q[axis_q];
  assign ss_hi = ss_q[37:SPLIT];
  assign tt_hi = tt_q[37:SPLIT];
  assign ss_lo = signed'({1'b0, ss_q[SPLIT-1:0]});
  assign tt_lo = signed'({1'b0, tt_q[SPLIT-1:0]});

  // issue stage: operand select and next sequencer state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    pre_d   = pre_q;
    part_d  = part_q;
    term_d  = term_q;
    row_d   = row_q;
    col_d   = col_q;
    slot_d  = slot_q;
    pstep_d = pstep_q;
    mul_a   = '0;
    mul_b   = '0;
    ctl_d   = '{dest: DST_NONE, first: 1'b0, hi: 1'b0, rnd: RND_0, idx: 2'd0};
    out_valid_d = out_valid_q;
    if (out_ch.valid && out_ch.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (eval_start) begin
          axis_d  = 1'b0;
          pre_d   = 1'b0;
          part_d  = 1'b0;
          term_d  = 2'd0;
          state_d = (eff_u == ORDER_CUBIC) ? ST_PRE : ST_TERM;
        end
      end
      ST_PRE: begin
        ctl_d.first = 1'b1;
        ctl_d.dest  = pre_q ? DST_TT : DST_SS;
        mul_a = pre_q ? 32'(t_c) : 32'(s_c);
        mul_b = mul_a;
        pre_d = ~pre_q;
        if (pre_q) state_d = ST_TERM;
      end
      ST_TERM: begin
        ctl_d.dest = axis_q ? DST_WV : DST_WU;
        ctl_d.idx  = term_q;
        case (ord_c)
          ORDER_MIN: begin
            ctl_d.first = 1'b1;
            ctl_d.rnd   = RND_8;
            mul_a = term_q[0] ? 32'(t_c) : 32'(s_c);
            mul_b = ONE_Q16;
          end
          ORDER_QUAD: begin
            ctl_d.first = 1'b1;
            ctl_d.rnd   = RND_8;
            case (term_q)
              2'd0: begin
                mul_a = 32'(s_c);
                mul_b = 32'(s_c);
              end
              2'd1: begin
                mul_a = 32'(s_c);
                mul_b = 32'(t_c) <<< 1;
              end
              default: begin
                mul_a = 32'(t_c);
                mul_b = 32'(t_c);
              end
            endcase
          end
          default: begin
            ctl_d.first = ~part_q;
            ctl_d.hi    = ~part_q;
            ctl_d.rnd   = RND_24;
            if (term_q[1]) mul_a = part_q ? 32'(tt_lo) : 32'(tt_hi);
            else mul_a = part_q ? 32'(ss_lo) : 32'(ss_hi);
            case (term_q)
              2'd0:    mul_b = 32'(s_c);
              2'd1:    mul_b = 32'(t3_q[axis_q]);
              2'd2:    mul_b = 32'(s3_q[axis_q]);
              default: mul_b = 32'(t_c);
            endcase
          end
        endcase
        if (ord_c == ORDER_CUBIC && !part_q) begin
          part_d = 1'b1;
        end else begin
          part_d = 1'b0;
          if (term_q == 2'(ord_c - 3'd1)) begin
            term_d = 2'd0;
            if (!axis_q) begin
              axis_d  = 1'b1;
              pre_d   = 1'b0;
              state_d = (eff_v == ORDER_CUBIC) ? ST_PRE : ST_TERM;
            end else begin
              state_d = ST_GAP;
            end
          end else begin
            term_d = term_q + 2'd1;
          end
        end
      end
      ST_GAP: begin
        row_d   = 2'd0;
        col_d   = 2'd0;
        slot_d  = '0;
        pstep_d = 2'd0;
        state_d = ST_POINT;
      end
      ST_POINT: begin
        pstep_d = pstep_q + 2'd1;
        case (pstep_q)
          2'd0: begin
            mul_a = wu_q[col_q];
            mul_b = wv_q[row_q];
            ctl_d.dest  = DST_W;
            ctl_d.first = 1'b1;
            ctl_d.rnd   = RND_32;
          end
          2'd2: begin
            mul_a = w_q;
            mul_b = xs_q[slot_q];
            ctl_d.dest = DST_X;
          end
          2'd3: begin
            mul_a = w_q;
            mul_b = ys_q[slot_q];
            ctl_d.dest = DST_Y;
            slot_d = slot_q + IDX_W'(1);
            if (col_q == 2'(eff_u - 3'd1)) begin
              col_d = 2'd0;
              row_d = row_q + 2'd1;
              if (row_q == 2'(eff_v - 3'd1)) state_d = ST_DRAIN;
            end else begin
              col_d = col_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // accumulate stage
  always_comb begin
    case (ctl_q.dest)
      DST_X: base = acc_x_q;
      DST_Y: base = acc_y_q;
      default: begin
        if (!ctl_q.first) base = acc_q;
        else begin
          case (ctl_q.rnd)
            RND_8:   base = RND_C8;
            RND_24:  base = RND_C24;
            RND_32:  base = RND_C32;
            default: base = '0;
          endcase
        end
      end
    endcase
    if (ctl_q.hi) addend = signed'({prod_q[ACC_W-SPLIT-1:0], {SPLIT{1'b0}}});
    else addend = ACC_W'(prod_q);
    sum = base + addend;
    case (ctl_q.rnd)
      RND_24:  w_ext = sum[55:24];
      RND_32:  w_ext = sum[63:32];
      default: w_ext = sum[39:8];
    endcase
  end

  assign sat_x = sat_out(acc_x_q);
  assign sat_y = sat_out(acc_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_u_q <= ORDER_RST;
      order_v_q <= ORDER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORDER_U: order_u_q <= cfg_data_i;
        CFG_ORDER_V: order_v_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      pre_q       <= 1'b0;
      part_q      <= 1'b0;
      term_q      <= 2'd0;
      row_q       <= 2'd0;
      col_q       <= 2'd0;
      slot_q      <= '0;
      pstep_q     <= 2'd0;
      ctl_q       <= '{dest: DST_NONE, first: 1'b0, hi: 1'b0, rnd: RND_0, idx: 2'd0};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      pre_q       <= pre_d;
      part_q      <= part_d;
      term_q      <= term_d;
      row_q       <= row_d;
      col_q       <= col_d;
      slot_q      <= slot_d;
      pstep_q     <= pstep_d;
      ctl_q       <= ctl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept && in_ch.kind == KIND_LOAD) begin
      xs_q[in_ch.point_index] <= in_ch.point_x;
      ys_q[in_ch.point_index] <= in_ch.point_y;
    end
    if (eval_start) begin
      t_q[0]  <= in_ch.param_u;
      t_q[1]  <= in_ch.param_v;
      s_q[0]  <= s_new_u;
      s_q[1]  <= s_new_v;
      s3_q[0] <= 21'(s_new_u) + (21'(s_new_u) <<< 1);
      s3_q[1] <= 21'(s_new_v) + (21'(s_new_v) <<< 1);
      t3_q[0] <= 20'(in_ch.param_u) + (20'(in_ch.param_u) <<< 1);
      t3_q[1] <= 20'(in_ch.param_v) + (20'(in_ch.param_v) <<< 1);
      acc_x_q <= RND_C16;
      acc_y_q <= RND_C16;
    end else begin
      case (ctl_q.dest)
        DST_SS: ss_q <= sum[37:0];
        DST_TT: tt_q <= sum[37:0];
        DST_WU: begin
          acc_q <= sum;
          wu_q[ctl_q.idx] <= w_ext;
        end
        DST_WV: begin
          acc_q <= sum;
          wv_q[ctl_q.idx] <= w_ext;
        end
        DST_W: w_q <= w_ext;
        DST_X: acc_x_q <= sum;
        DST_Y: acc_y_q <= sum;
        default: ;
      endcase
    end
    if (out_load) begin
      out_x_q   <= sat_x[COORD_W-1:0];
      out_y_q   <= sat_y[COORD_W-1:0];
      out_ovf_q <= sat_x[COORD_W] | sat_y[COORD_W];
    end
  end

endmodule
